### design/jtlsm_pkg.sv
// ----------------------------------------------------------------------------
// jtlsm_pkg
// Shared types and constants of the joint torque and lean safety monitor.
// ----------------------------------------------------------------------------
package jtlsm_pkg;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int RESULT_DEPTH   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int JOINT_W    = 5;

  // Product widths: 17 x 17 signed products, exact
  localparam int PROD_W  = 34;
  localparam int TAU_W   = PROD_W + 1;
  localparam int BOUND_W = 26;

  localparam logic [14:0] MAX_LEAN_RST     = 15'd2145;
  localparam logic [9:0]  TORQUE_SCALE_RST = 10'd256;
  localparam logic        TORQUE_EN_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEAN     = 2'd0,
    CFG_TORQUE_SCALE = 2'd1,
    CFG_TORQUE_EN    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_LEAN   = 2'd1,
    CAUSE_TORQUE = 2'd2,
    CAUSE_RSVD   = 2'd3
  } cause_t;

  typedef struct packed {
    logic [14:0] max_lean;
    logic [9:0]  torque_scale;
    logic        torque_check_en;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_d;
    logic [BOUND_W-1:0]       bound;
    logic                     lean_fail;
    logic                     first;
    logic                     last;
  } front_item_t;

  typedef struct packed {
    logic               safe;
    cause_t             cause;
    logic [JOINT_W-1:0] fault_joint;
  } result_t;

endpackage

### design/jtlsm_fifo.sv
// ----------------------------------------------------------------------------
// jtlsm_fifo
// Small register queue with push/full and pop/empty, head shown while not empty.
// ----------------------------------------------------------------------------
module jtlsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == DepthC);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/jtlsm_front.sv
// ----------------------------------------------------------------------------
// jtlsm_front
// Accepts joint items, forms the three products and the lean test, and
// hands each classified item to the joint queue.
// ----------------------------------------------------------------------------
module jtlsm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  jtlsm_pkg::cfg_t          cfg,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [15:0]       in_roll,
  input  logic signed [15:0]       in_pitch,
  input  logic signed [15:0]       in_pos_cmd,
  input  logic signed [15:0]       in_q_meas,
  input  logic signed [15:0]       in_dq_meas,
  input  logic [15:0]              in_gain_p,
  input  logic [15:0]              in_gain_d,
  input  logic [15:0]              in_tau_max,
  input  logic                     in_first,
  input  logic                     in_last,
  output logic                     q_push,
  output jtlsm_pkg::front_item_t   q_item,
  input  logic                     q_full
);

  logic                                valid_r, valid_nxt;
  jtlsm_pkg::front_item_t              item_r;
  logic                                accept;
  logic signed [16:0]                  pos_err;
  logic signed [16:0]                  kp_s, kd_s, dq_s;
  logic signed [jtlsm_pkg::PROD_W-1:0] prod_p, prod_d;
  logic [jtlsm_pkg::BOUND_W-1:0]       bound;
  logic [15:0]                         abs_roll, abs_pitch, lean;

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_item  = item_r;

  assign pos_err = $signed({in_pos_cmd[15], in_pos_cmd}) -
                   $signed({in_q_meas[15], in_q_meas});
  assign kp_s    = $signed({1'b0, in_gain_p});
  assign kd_s    = $signed({1'b0, in_gain_d});
  assign dq_s    = $signed({in_dq_meas[15], in_dq_meas});

  // products sized by their targets, so every bit is kept
  assign prod_p = pos_err * kp_s;
  assign prod_d = dq_s * kd_s;
  assign bound  = in_tau_max * cfg.torque_scale;

  // 16-bit magnitude holds 32768 for the most negative angle
  assign abs_roll  = in_roll[15]  ? (~in_roll + 16'd1)  : in_roll;
  assign abs_pitch = in_pitch[15] ? (~in_pitch + 16'd1) : in_pitch;
  assign lean      = (abs_roll > abs_pitch) ? abs_roll : abs_pitch;

  assign valid_nxt = accept || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.prod_p    <= prod_p;
      item_r.prod_d    <= prod_d;
      item_r.bound     <= bound;
      item_r.lean_fail <= in_first && (lean > {1'b0, cfg.max_lean});
      item_r.first     <= in_first;
      item_r.last      <= in_last;
    end
  end

endmodule

### design/jtlsm_back.sv
// ----------------------------------------------------------------------------
// jtlsm_back
// Finishes the torque check, keeps the frame fault latch and joint index,
// and writes one result per frame into the result queue.
// ----------------------------------------------------------------------------
module jtlsm_back #(
  parameter int MAX_JOINTS = jtlsm_pkg::MAX_JOINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   torque_check_en,
  input  logic                   q_empty,
  input  jtlsm_pkg::front_item_t q_item,
  output logic                   q_pop,
  output logic                   r_push,
  output jtlsm_pkg::result_t     r_item,
  input  logic                   r_full
);

  localparam int TopInt = ((MAX_JOINTS < 32) ? MAX_JOINTS : 32) - 1;
  localparam logic [jtlsm_pkg::JOINT_W-1:0] TopIndex = TopInt[jtlsm_pkg::JOINT_W-1:0];

  logic                              latched_r, latched_nxt;
  jtlsm_pkg::cause_t                 cause_r, cause_nxt;
  logic [jtlsm_pkg::JOINT_W-1:0]     index_r, index_nxt;
  logic [jtlsm_pkg::JOINT_W-1:0]     count_r, count_nxt;

  logic                              lat_v;
  jtlsm_pkg::cause_t                 cause_v;
  logic [jtlsm_pkg::JOINT_W-1:0]     index_v, count_v;
  logic signed [jtlsm_pkg::TAU_W-1:0] tau;
  logic [jtlsm_pkg::TAU_W-1:0]       tau_mag;
  logic [jtlsm_pkg::TAU_W-1:0]       bound_x4;
  logic                              torque_fail;

  assign q_pop  = !q_empty && !r_full;
  assign r_push = q_pop && q_item.last;

  assign tau = jtlsm_pkg::TAU_W'(q_item.prod_p) - jtlsm_pkg::TAU_W'(q_item.prod_d);
  assign tau_mag  = tau[jtlsm_pkg::TAU_W-1] ? jtlsm_pkg::TAU_W'(-tau)
                                            : jtlsm_pkg::TAU_W'(tau);
  assign bound_x4 = jtlsm_pkg::TAU_W'({q_item.bound, 2'b00});

  always_comb begin
    // a first item restarts the frame before its own checks
    lat_v   = q_item.first ? q_item.lean_fail : latched_r;
    cause_v = q_item.first ? (q_item.lean_fail ? jtlsm_pkg::CAUSE_LEAN
                                               : jtlsm_pkg::CAUSE_NONE)
                           : cause_r;
    index_v = q_item.first ? '0 : index_r;
    count_v = q_item.first ? '0 : count_r;

    torque_fail = !lat_v && torque_check_en && (tau_mag > bound_x4);

    latched_nxt = lat_v;
    cause_nxt   = cause_v;
    index_nxt   = index_v;
    if (torque_fail) begin
      latched_nxt = 1'b1;
      cause_nxt   = jtlsm_pkg::CAUSE_TORQUE;
      index_nxt   = count_v;
    end
    count_nxt = (count_v < TopIndex) ? count_v + 1'b1 : count_v;

    r_item.safe        = !latched_nxt;
    r_item.cause       = latched_nxt ? cause_nxt : jtlsm_pkg::CAUSE_NONE;
    r_item.fault_joint = (latched_nxt && cause_nxt == jtlsm_pkg::CAUSE_TORQUE) ?
                         index_nxt : '0;

    // drop the frame state once reported
    if (q_item.last) begin
      latched_nxt = 1'b0;
      cause_nxt   = jtlsm_pkg::CAUSE_NONE;
      index_nxt   = '0;
      count_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      cause_r   <= jtlsm_pkg::CAUSE_NONE;
      index_r   <= '0;
      count_r   <= '0;
    end else if (q_pop) begin
      latched_r <= latched_nxt;
      cause_r   <= cause_nxt;
      index_r   <= index_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

### design/joint_torque_lean_safety_monitor_core.sv
// ----------------------------------------------------------------------------
// joint_torque_lean_safety_monitor_core
// Per-frame joint torque and body lean safety monitor.
//
//   channel  handshake              payload
//   in_      in_push / in_full      roll, pitch, pos_cmd, q_meas, dq_meas,
//                                   gain_p, gain_d, tau_max, first, last
//   out_     out_pop / out_empty    safe, cause, fault_joint
//   cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while the result side does not stall, set by the
// registered product stage in the front and the latch update in the back. A result
// reaches the out_ ports through the front item register, the joint queue and the
// result queue.
// Reset clears queues, fault latch and joint index and loads register
// defaults. A stalled result side fills the joint queue, then raises in_full.
// ----------------------------------------------------------------------------
module joint_torque_lean_safety_monitor_core #(
  parameter int MAX_JOINTS   = jtlsm_pkg::MAX_JOINTS_DEF,
  parameter int QUEUE_DEPTH  = jtlsm_pkg::QUEUE_DEPTH,
  parameter int RESULT_DEPTH = jtlsm_pkg::RESULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jtlsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jtlsm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [15:0]                   in_roll,
  input  logic signed [15:0]                   in_pitch,
  input  logic signed [15:0]                   in_pos_cmd,
  input  logic signed [15:0]                   in_q_meas,
  input  logic signed [15:0]                   in_dq_meas,
  input  logic [15:0]                          in_gain_p,
  input  logic [15:0]                          in_gain_d,
  input  logic [15:0]                          in_tau_max,
  input  logic                                 in_first,
  input  logic                                 in_last,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic                                 out_safe,
  output logic [1:0]                           out_cause,
  output logic [jtlsm_pkg::JOINT_W-1:0]        out_fault_joint
);

  localparam int ItemW   = $bits(jtlsm_pkg::front_item_t);
  localparam int ResultW = $bits(jtlsm_pkg::result_t);

  jtlsm_pkg::cfg_t          cfg_r, cfg_nxt;
  logic                     q_push, q_full, q_pop, q_empty;
  jtlsm_pkg::front_item_t   q_wr_item, q_rd_item;
  logic                     r_push, r_full;
  jtlsm_pkg::result_t       r_wr_item, r_rd_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (jtlsm_pkg::cfg_idx_t'(cfg_index))
        jtlsm_pkg::CFG_MAX_LEAN:     cfg_nxt.max_lean        = cfg_data[14:0];
        jtlsm_pkg::CFG_TORQUE_SCALE: cfg_nxt.torque_scale    = cfg_data[9:0];
        jtlsm_pkg::CFG_TORQUE_EN:    cfg_nxt.torque_check_en = cfg_data[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lean        <= jtlsm_pkg::MAX_LEAN_RST;
      cfg_r.torque_scale    <= jtlsm_pkg::TORQUE_SCALE_RST;
      cfg_r.torque_check_en <= jtlsm_pkg::TORQUE_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jtlsm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_roll         (in_roll),
    .in_pitch        (in_pitch),
    .in_pos_cmd      (in_pos_cmd),
    .in_q_meas       (in_q_meas),
    .in_dq_meas      (in_dq_meas),
    .in_gain_p       (in_gain_p),
    .in_gain_d       (in_gain_d),
    .in_tau_max      (in_tau_max),
    .in_first        (in_first),
    .in_last         (in_last),
    .q_push          (q_push),
    .q_item          (q_wr_item),
    .q_full          (q_full)
  );

  jtlsm_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QUEUE_DEPTH)
  ) u_joint_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_item),
    .empty     (q_empty)
  );

  jtlsm_back #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .torque_check_en (cfg_r.torque_check_en),
    .q_empty         (q_empty),
    .q_item          (q_rd_item),
    .q_pop           (q_pop),
    .r_push          (r_push),
    .r_item          (r_wr_item),
    .r_full          (r_full)
  );

  jtlsm_fifo #(
    .WIDTH (ResultW),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (r_push),
    .push_data (r_wr_item),
    .full      (r_full),
    .pop       (out_pop),
    .pop_data  (r_rd_item),
    .empty     (out_empty)
  );

  assign out_safe        = r_rd_item.safe;
  assign out_cause       = r_rd_item.cause;
  assign out_fault_joint = r_rd_item.fault_joint;

endmodule

### tb/tb_joint_torque_lean_safety_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_torque_lean_safety_monitor_core
// Self-checking bench for the joint torque and body lean safety monitor.
// Frames of joint items go in through the push/full queue port. A frame
// verdict predictor runs beside the core, and every popped result is
// compared field by field with the oldest predicted verdict. Directed
// frames cover the lean and torque boundaries and the frame-boundary
// cases, long frames cover joint index saturation, and register sweeps and
// random traffic with random gaps and stalls on both sides cover the rest.
// ----------------------------------------------------------------------------
module tb_joint_torque_lean_safety_monitor_core;

  localparam int LATENCY    = 3;
  localparam int IDLE_LIMIT = 1000;
  localparam int TOP_JOINT  =
    (jtlsm_pkg::MAX_JOINTS_DEF < 32 ? jtlsm_pkg::MAX_JOINTS_DEF : 32) - 1;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] pos_cmd;
    logic signed [15:0] q_meas;
    logic signed [15:0] dq_meas;
    logic [15:0]        gain_p;
    logic [15:0]        gain_d;
    logic [15:0]        tau_max;
    logic               first;
    logic               last;
  } joint_item_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [jtlsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jtlsm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_push;
  logic in_full;
  logic signed [15:0] in_roll;
  logic signed [15:0] in_pitch;
  logic signed [15:0] in_pos_cmd;
  logic signed [15:0] in_q_meas;
  logic signed [15:0] in_dq_meas;
  logic [15:0] in_gain_p;
  logic [15:0] in_gain_d;
  logic [15:0] in_tau_max;
  logic in_first;
  logic in_last;
  logic out_pop;
  logic out_empty;
  logic out_safe;
  logic [1:0] out_cause;
  logic [jtlsm_pkg::JOINT_W-1:0] out_fault_joint;

  // Predictor copy of the registers and the frame latch
  logic [14:0]                   lean_limit = jtlsm_pkg::MAX_LEAN_RST;
  logic [9:0]                    scale_q8   = jtlsm_pkg::TORQUE_SCALE_RST;
  logic                          torque_on  = jtlsm_pkg::TORQUE_EN_RST;
  logic                          fault_held;
  jtlsm_pkg::cause_t             fault_why;
  logic [jtlsm_pkg::JOINT_W-1:0] fault_at;
  int                            joint_idx;

  jtlsm_pkg::result_t verdict_q[$];
  jtlsm_pkg::result_t want;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      pop_hold = 0;
  bit      gaps_on = 1'b1;

  joint_torque_lean_safety_monitor_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_roll         (in_roll),
    .in_pitch        (in_pitch),
    .in_pos_cmd      (in_pos_cmd),
    .in_q_meas       (in_q_meas),
    .in_dq_meas      (in_dq_meas),
    .in_gain_p       (in_gain_p),
    .in_gain_d       (in_gain_d),
    .in_tau_max      (in_tau_max),
    .in_first        (in_first),
    .in_last         (in_last),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_safe        (out_safe),
    .out_cause       (out_cause),
    .out_fault_joint (out_fault_joint)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic clear_frame();
    fault_held = 1'b0;
    fault_why  = jtlsm_pkg::CAUSE_NONE;
    fault_at   = '0;
    joint_idx  = 0;
  endtask

  // Advance the frame verdict by one accepted joint; queue a verdict on last
  task automatic apply_joint(input joint_item_t j);
    longint ar, ap, tau, bound;
    jtlsm_pkg::result_t v;
    if (j.first) begin
      clear_frame();
      ar = (j.roll < 0) ? -longint'(j.roll) : longint'(j.roll);
      ap = (j.pitch < 0) ? -longint'(j.pitch) : longint'(j.pitch);
      if ((ar > ap ? ar : ap) > longint'(lean_limit)) begin
        fault_held = 1'b1;
        fault_why  = jtlsm_pkg::CAUSE_LEAN;
        fault_at   = '0;
      end
    end
    if (!fault_held && torque_on) begin
      tau = longint'(j.gain_p) * (longint'(j.pos_cmd) - longint'(j.q_meas))
            - longint'(j.gain_d) * longint'(j.dq_meas);
      bound = longint'(j.tau_max) * longint'(scale_q8) * 4;
      if (tau < 0) tau = -tau;
      if (tau > bound) begin
        fault_held = 1'b1;
        fault_why  = jtlsm_pkg::CAUSE_TORQUE;
        fault_at   = joint_idx[jtlsm_pkg::JOINT_W-1:0];
      end
    end
    if (joint_idx < TOP_JOINT) joint_idx++;
    if (j.last) begin
      v.safe        = !fault_held;
      v.cause       = fault_held ? fault_why : jtlsm_pkg::CAUSE_NONE;
      v.fault_joint = (fault_held && fault_why == jtlsm_pkg::CAUSE_TORQUE) ? fault_at : '0;
      verdict_q.push_back(v);
      clear_frame();
    end
  endtask

  task automatic send_joint(input joint_item_t j);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_roll         <= j.roll;
    in_pitch        <= j.pitch;
    in_pos_cmd      <= j.pos_cmd;
    in_q_meas       <= j.q_meas;
    in_dq_meas      <= j.dq_meas;
    in_gain_p       <= j.gain_p;
    in_gain_d       <= j.gain_d;
    in_tau_max      <= j.tau_max;
    in_first        <= j.first;
    in_last         <= j.last;
    in_push         <= 1'b1;
    do @(posedge clk); while (in_full);
    apply_joint(j);
  endtask

  // Hold the input side until every verdict is out and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input jtlsm_pkg::cfg_idx_t idx, input logic [14:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jtlsm_pkg::CFG_MAX_LEAN:     lean_limit = data;
      jtlsm_pkg::CFG_TORQUE_SCALE: scale_q8   = data[9:0];
      jtlsm_pkg::CFG_TORQUE_EN:    torque_on  = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [14:0] lean, input logic [14:0] scale,
                               input logic [14:0] enable);
    drain();
    write_reg(jtlsm_pkg::CFG_MAX_LEAN, lean);
    write_reg(jtlsm_pkg::CFG_TORQUE_SCALE, scale);
    write_reg(jtlsm_pkg::CFG_TORQUE_EN, enable);
  endtask

  function automatic joint_item_t mk(input int roll, input int pitch, input int qt,
                                     input int qm, input int dq, input int gp,
                                     input int gd, input int lim, input bit first,
                                     input bit last);
    joint_item_t j;
    j.roll = 16'(roll);
    j.pitch = 16'(pitch);
    j.pos_cmd = 16'(qt);
    j.q_meas = 16'(qm);
    j.dq_meas = 16'(dq);
    j.gain_p = 16'(gp);
    j.gain_d = 16'(gd);
    j.tau_max = 16'(lim);
    j.first = first;
    j.last = last;
    return j;
  endfunction

  // tau of 2000 against a bound of 1024 at the default scale
  function automatic joint_item_t hot_joint(input bit first, input bit last);
    return mk(0, 0, 2000, 0, 0, 1, 0, 1, first, last);
  endfunction

  function automatic joint_item_t calm_joint(input bit first, input bit last);
    return mk(0, 0, 0, 0, 0, 0, 0, 0, first, last);
  endfunction

  function automatic joint_item_t random_joint(input bit first, input bit last);
    joint_item_t j;
    if ($urandom_range(0, 3) == 0) begin
      j.roll  = 16'($urandom);
      j.pitch = 16'($urandom);
    end else begin
      j.roll  = 16'(int'($urandom_range(0, 6000)) - 3000);
      j.pitch = 16'(int'($urandom_range(0, 6000)) - 3000);
    end
    if ($urandom_range(0, 3) == 0) begin
      j.pos_cmd = 16'($urandom);
      j.q_meas  = 16'($urandom);
      j.dq_meas = 16'($urandom);
      j.gain_p  = 16'($urandom);
      j.gain_d  = 16'($urandom);
    end else begin
      // keep tau near typical limits so both verdicts turn up
      j.pos_cmd = 16'($urandom);
      j.q_meas  = 16'(int'(j.pos_cmd) + (int'($urandom_range(0, 2048)) - 1024));
      j.dq_meas = 16'(int'($urandom_range(0, 4096)) - 2048);
      j.gain_p  = 16'($urandom_range(0, 511));
      j.gain_d  = 16'($urandom_range(0, 255));
    end
    j.tau_max = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2047));
    j.first = first;
    j.last  = last;
    return j;
  endfunction

  task automatic run_random_frames(input int n_items);
    int sent;
    int len;
    bit broken;
    joint_item_t j;
    sent = 0;
    while (sent < n_items) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      broken  = ($urandom_range(0, 99) < 15);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        if (broken) j = random_joint(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else j = random_joint(k == 0, k == len - 1);
        send_joint(j);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_directed_frames();
    // lean threshold is inclusive, and either axis and sign trips it
    send_joint(mk(2145, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_joint(mk(2146, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_joint(mk(0, -2146, 0, 0, 0, 0, 0, 0, 1, 1));
    send_joint(mk(-32768, 32767, 0, 0, 0, 0, 0, 0, 1, 1));
    // torque bound of 1024: equal passes, one over fails in either sign
    send_joint(mk(0, 0, 1024, 0, 0, 1, 0, 1, 1, 1));
    send_joint(mk(0, 0, 1025, 0, 0, 1, 0, 1, 1, 1));
    send_joint(mk(0, 0, 0, 1025, 0, 1, 0, 1, 1, 1));
    // first failing joint is reported, later ones ignored
    send_joint(calm_joint(1, 0));
    send_joint(hot_joint(0, 0));
    send_joint(hot_joint(0, 1));
    // lean fault wins over a joint fault in the same frame
    send_joint(mk(3000, 0, 2000, 0, 0, 1, 0, 1, 1, 0));
    send_joint(hot_joint(0, 1));
    // frame without a first marker: no lean check, index restarts at 0
    send_joint(mk(-32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
    send_joint(hot_joint(0, 1));
    // field extremes
    send_joint(mk(0, 0, 32767, -32768, 0, 65535, 0, 65535, 1, 1));
    send_joint(mk(0, 0, -32768, 32767, 0, 65535, 0, 65535, 1, 1));
    send_joint(mk(0, 0, 0, 0, -32768, 0, 65535, 65535, 1, 1));
    send_joint(mk(0, 0, 0, 0, 32767, 0, 65535, 65535, 1, 1));
    send_joint(mk(0, 0, 0, 0, 1, 0, 1, 0, 1, 1));
    send_joint(calm_joint(1, 1));
    // a first in mid-frame restarts the frame
    send_joint(hot_joint(1, 0));
    send_joint(calm_joint(1, 1));
  endtask

  task automatic test_long_frames();
    for (int k = 0; k < 32; k++) send_joint((k == 31) ? hot_joint(0, 1) : calm_joint(k == 0, 0));
    for (int k = 0; k < 37; k++) begin
      if (k == 35) send_joint(hot_joint(0, 0));
      else send_joint(calm_joint(k == 0, k == 36));
    end
    for (int k = 0; k < 40; k++) begin
      if (k == 3 || k == 20) send_joint(hot_joint(0, k == 39));
      else send_joint(calm_joint(k == 0, k == 39));
    end
    for (int k = 0; k < 64; k++) send_joint(calm_joint(k == 0, k == 63));
    send_joint(hot_joint(1, 1));
  endtask

  task automatic test_register_sweep();
    apply_setting(15'd0, 15'h7C00, 15'd1);
    run_random_frames(140);
    apply_setting(15'h7FFF, 15'd1023, 15'd1);
    run_random_frames(140);
    // torque check off: a hot joint must pass
    apply_setting(15'd2145, 15'd256, 15'h7FFE);
    send_joint(hot_joint(1, 1));
    run_random_frames(140);
    apply_setting(15'd100, 15'd1, 15'd1);
    run_random_frames(140);
    apply_setting(15'h7FFF, 15'h7FFF, 15'd0);
    run_random_frames(140);
    apply_setting(15'($urandom), 15'($urandom), 15'($urandom));
    run_random_frames(140);
    apply_setting(15'($urandom), 15'($urandom), 15'($urandom));
    write_reg(jtlsm_pkg::CFG_UNUSED, 15'($urandom));
    run_random_frames(140);
    apply_setting(jtlsm_pkg::MAX_LEAN_RST, 15'(jtlsm_pkg::TORQUE_SCALE_RST),
                  15'(jtlsm_pkg::TORQUE_EN_RST));
  endtask

  task automatic test_random_traffic();
    run_random_frames(700);
  endtask

  // Result side: check each popped transaction, draw the next stall
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch("result with no verdict pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_safe !== want.safe)
          flag_mismatch($sformatf("safe exp %0d got %0d", want.safe, out_safe));
        if (out_cause !== want.cause)
          flag_mismatch($sformatf("cause exp %0d got %0d", want.cause, out_cause));
        if (out_fault_joint !== want.fault_joint)
          flag_mismatch($sformatf("fault_joint exp %0d got %0d", want.fault_joint,
                                  out_fault_joint));
      end
      pop_hold <= gaps_on ? $urandom_range(0, 4) : 0;
    end
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("[joint_torque_lean_safety_monitor_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (pop_hold != 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = jtlsm_pkg::CFG_MAX_LEAN;
    cfg_data = '0;
    in_push = 1'b0;
    in_roll = '0;
    in_pitch = '0;
    in_pos_cmd = '0;
    in_q_meas = '0;
    in_dq_meas = '0;
    in_gain_p = '0;
    in_gain_d = '0;
    in_tau_max = '0;
    in_first = 1'b0;
    in_last = 1'b0;
    out_pop = 1'b0;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_long_frames();
    test_register_sweep();
    test_random_traffic();
    drain();

    if (mismatch_count == 0)
      $display("[joint_torque_lean_safety_monitor_core] OK");
    else
      $display("[joint_torque_lean_safety_monitor_core] ERROR");
    $finish;
  end

endmodule
